[hdl/assert_macros.svh]
// assertion macros used by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge out of reset
`define PTWA_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define PTWA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define PTWA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PTWA_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define PTWA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PTWA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[hdl/ptwa_pkg.sv]
// shared types and constants of the peer table
package ptwa_pkg;

    localparam int SLOTS_DEF  = 8;
    localparam int MAC_W      = 48;
    localparam int TIME_W     = 32;
    localparam int MEDIA_W    = 8;
    localparam int OUT_SLOT_W = 3;

    localparam logic [TIME_W-1:0] MISSING_LIMIT_RST = TIME_W'(5000);
    localparam logic [TIME_W-1:0] REMOVE_LIMIT_RST  = TIME_W'(10000);

    typedef enum logic {
        OP_INFO  = 1'b0,
        OP_SWEEP = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        EV_REFRESHED   = 3'd0,
        EV_RECONNECTED = 3'd1,
        EV_ADDED       = 3'd2,
        EV_FULL        = 3'd3,
        EV_IGNORED     = 3'd4,
        EV_MISSING     = 3'd5,
        EV_REMOVED     = 3'd6,
        EV_DONE        = 3'd7
    } event_t;

    // item walking down the row of cells
    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [TIME_W-1:0] now;
        logic [MAC_W-1:0]  mac;
        logic              free_found;
    } probe_t;

    // result offered to the output register
    typedef struct packed {
        logic                  valid;
        event_t                ev;
        logic [OUT_SLOT_W-1:0] slot;
        logic [MAC_W-1:0]      mac;
        logic                  last;
    } res_t;

    // write of a new peer into a free cell
    typedef struct packed {
        logic              valid;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] now;
    } fill_t;

endpackage

[hdl/ptwa_cell.sv]
// one peer slot of the table, processing the probe that passes through it
module ptwa_cell #(
    parameter int SLOTS = ptwa_pkg::SLOTS_DEF,
    parameter int IDX   = 0
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic [ptwa_pkg::TIME_W-1:0]             missing_limit,
    input  logic [ptwa_pkg::TIME_W-1:0]             remove_limit,
    input  ptwa_pkg::probe_t                        probe_in,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] free_in,
    output logic                                    take_in,
    output ptwa_pkg::probe_t                        probe_out,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] free_out,
    input  logic                                    take_out,
    input  logic                                    out_free,
    output ptwa_pkg::res_t                          res,
    input  ptwa_pkg::fill_t                         fill,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] fill_slot
);
    import ptwa_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(IDX);

    logic [MAC_W-1:0]  mac_reg, mac_next;
    logic [TIME_W-1:0] seen_reg, seen_next;
    logic              active_reg, active_next;
    logic              connected_reg, connected_next;
    probe_t            probe_reg, probe_next;
    logic [SLOT_W-1:0] free_reg, free_next;

    logic [TIME_W-1:0]            elapsed;
    logic                         hit;
    logic                         miss;
    logic                         rem;
    logic                         emit;
    logic                         hold;
    logic                         fwd;
    logic                         go;
    logic [SLOT_W+OUT_SLOT_W-1:0] slot_ext;

    assign slot_ext = {{OUT_SLOT_W{1'b0}}, MY_IDX};

    always_comb begin
        mac_next       = mac_reg;
        seen_next      = seen_reg;
        active_next    = active_reg;
        connected_next = connected_reg;
        probe_next     = probe_reg;
        free_next      = free_reg;

        elapsed = probe_in.now - seen_reg;
        hit     = active_reg && (mac_reg == probe_in.mac);
        miss    = connected_reg && (elapsed > missing_limit);
        rem     = elapsed > remove_limit;

        case (probe_in.op)
            OP_INFO: begin
                emit = hit;
                hold = 1'b0;
                fwd  = !hit;
            end
            OP_SWEEP: begin
                emit = active_reg && (miss || rem);
                // both limits passed: missing now, then the probe is held here and removed follows in the same sweep
                hold = active_reg && miss && rem;
                fwd  = 1'b1;
            end
            default: begin
                emit = 1'b0;
                hold = 1'b0;
                fwd  = 1'b1;
            end
        endcase

        go      = probe_in.valid && (!emit || out_free);
        take_in = go && !hold;

        res.valid = probe_in.valid && emit;
        res.slot  = slot_ext[OUT_SLOT_W-1:0];
        res.mac   = mac_reg;
        res.last  = (probe_in.op == OP_INFO);
        if (probe_in.op == OP_INFO) begin
            res.ev = connected_reg ? EV_REFRESHED : EV_RECONNECTED;
        end else begin
            res.ev = miss ? EV_MISSING : EV_REMOVED;
        end

        if (go && emit) begin
            if (probe_in.op == OP_INFO) begin
                seen_next      = probe_in.now;
                connected_next = 1'b1;
            end else if (miss) begin
                connected_next = 1'b0;
            end else begin
                active_next    = 1'b0;
                connected_next = 1'b0;
            end
        end

        if (fill.valid && (fill_slot == MY_IDX)) begin
            mac_next       = fill.mac;
            seen_next      = fill.now;
            active_next    = 1'b1;
            connected_next = 1'b1;
        end

        if (take_in) begin
            probe_next       = probe_in;
            probe_next.valid = fwd;
            free_next        = free_in;
            if (probe_in.op == OP_INFO && !active_reg && !probe_in.free_found) begin
                probe_next.free_found = 1'b1;
                free_next             = MY_IDX;
            end
        end else if (take_out) begin
            probe_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= 1'b0;
            connected_reg   <= 1'b0;
            probe_reg.valid <= 1'b0;
        end else begin
            active_reg    <= active_next;
            connected_reg <= connected_next;
            probe_reg     <= probe_next;
        end
    end

    always_ff @(posedge aclk) begin
        mac_reg  <= mac_next;
        seen_reg <= seen_next;
        free_reg <= free_next;
    end

    assign probe_out = probe_reg;
    assign free_out  = free_reg;

endmodule

[hdl/peer_table_with_aging.sv]
// top level of the peer table with aging
// A table of SLOTS peers keyed by 48-bit mac, built as a row of cells that
// each hold one slot. An accepted item is registered in an entry stage, then
// walks the row from cell to cell and finishes in a tail stage; a sweep is
// held at each slot that is reported both missing and removed, and a stall
// on the output holds an item that has a result to give. An info packet that
// matches a slot ends at that cell. One item is in the row at a time; the
// next beat is taken once the last result of the current one has moved into
// the output register. A short info packet is answered from the entry stage.
// The media index is accepted but not kept, since no result reports it.
// Config registers (missing limit at 0x0, remove limit at 0x4) are to be
// written while the block is idle.
`include "assert_macros.svh"

module peer_table_with_aging #(
    parameter int SLOTS = ptwa_pkg::SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beat
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // now_ms[31:0], src_mac[79:32], media_index[87:80]
    input  logic [1:0]  s_tuser,   // op[0], short_packet[1]
    // result beat
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // slot[2:0], peer_mac[50:3], zero pad[55:51]
    output logic [2:0]  m_tuser,   // event_res[2:0]
    output logic        m_tlast,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ptwa_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // config registers
    logic [TIME_W-1:0] missing_reg;
    logic [TIME_W-1:0] remove_reg;
    logic              cfg_wr;

    // entry stage
    probe_t entry_reg, entry_next;
    logic   short_reg, short_next;
    probe_t entry_probe;
    logic   entry_short;
    logic   ign_go;
    logic   accept;

    // row of cells
    probe_t            cell_in    [SLOTS];
    probe_t            cell_out   [SLOTS];
    logic [SLOT_W-1:0] cell_fin   [SLOTS];
    logic [SLOT_W-1:0] cell_fout  [SLOTS];
    logic              cell_take  [SLOTS];
    logic              cell_ntake [SLOTS];
    res_t              cell_res   [SLOTS];

    // tail stage
    probe_t                       tail_probe;
    logic [SLOT_W-1:0]            tail_free;
    logic                         tail_go;
    logic [SLOT_W+OUT_SLOT_W-1:0] tail_slot_ext;
    fill_t                        fill;

    // result selection and output register
    res_t                  sel;
    logic                  out_free;
    logic                  busy;
    logic [SLOTS:0]        probe_vld;
    logic [SLOTS+1:0]      emit_vec;
    logic                  m_tvalid_reg;
    event_t                ev_reg;
    logic [OUT_SLOT_W-1:0] slot_reg;
    logic [MAC_W-1:0]      mac_reg;
    logic                  last_reg;

    // config port: register index is paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? remove_reg : missing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            missing_reg <= MISSING_LIMIT_RST;
            remove_reg  <= REMOVE_LIMIT_RST;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                remove_reg <= pwdata;
            end else begin
                missing_reg <= pwdata;
            end
        end
    end

    // one item in flight: accept only when the whole row is empty
    always_comb begin
        probe_vld[0] = entry_reg.valid;
        for (int i = 0; i < SLOTS; i++) begin
            probe_vld[i+1] = cell_out[i].valid;
        end
    end

    assign busy     = |probe_vld;
    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // entry stage: short info packets answered here, the rest go to the row
    assign entry_short = entry_reg.valid && (entry_reg.op == OP_INFO) && short_reg;
    assign ign_go      = entry_short && out_free;

    always_comb begin
        entry_probe       = entry_reg;
        entry_probe.valid = entry_reg.valid && !entry_short;
    end

    always_comb begin
        entry_next = entry_reg;
        short_next = short_reg;
        if (ign_go || cell_take[0]) begin
            entry_next.valid = 1'b0;
        end
        if (accept) begin
            entry_next.valid      = 1'b1;
            entry_next.op         = op_t'(s_tuser[0]);
            entry_next.now        = s_tdata[31:0];
            entry_next.mac        = s_tdata[79:32];
            entry_next.free_found = 1'b0;
            short_next            = s_tuser[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    always_ff @(posedge aclk) begin
        short_reg <= short_next;
    end

    // the row: each cell hands the probe to its right neighbor
    for (genvar gi = 0; gi < SLOTS; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            assign cell_in[gi]  = entry_probe;
            assign cell_fin[gi] = '0;
        end else begin : g_body
            assign cell_in[gi]  = cell_out[gi-1];
            assign cell_fin[gi] = cell_fout[gi-1];
        end

        if (gi == SLOTS - 1) begin : g_last
            assign cell_ntake[gi] = tail_go;
        end else begin : g_mid
            assign cell_ntake[gi] = cell_take[gi+1];
        end

        ptwa_cell #(
            .SLOTS (SLOTS),
            .IDX   (gi)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .missing_limit (missing_reg),
            .remove_limit  (remove_reg),
            .probe_in      (cell_in[gi]),
            .free_in       (cell_fin[gi]),
            .take_in       (cell_take[gi]),
            .probe_out     (cell_out[gi]),
            .free_out      (cell_fout[gi]),
            .take_out      (cell_ntake[gi]),
            .out_free      (out_free),
            .res           (cell_res[gi]),
            .fill          (fill),
            .fill_slot     (tail_free)
        );
    end

    // tail: info packet with no match adds or reports full, sweep ends done
    assign tail_probe    = cell_out[SLOTS-1];
    assign tail_free     = cell_fout[SLOTS-1];
    assign tail_go       = tail_probe.valid && out_free;
    assign tail_slot_ext = {{OUT_SLOT_W{1'b0}}, tail_free};

    always_comb begin
        fill.valid = tail_go && (tail_probe.op == OP_INFO) && tail_probe.free_found;
        fill.mac   = tail_probe.mac;
        fill.now   = tail_probe.now;
    end

    // at most one emitter at a time, so a plain priority pick is enough
    always_comb begin
        sel = '0;
        emit_vec[0] = entry_short;
        if (entry_short) begin
            sel.valid = 1'b1;
            sel.ev    = EV_IGNORED;
            sel.last  = 1'b1;
        end
        for (int i = 0; i < SLOTS; i++) begin
            emit_vec[i+1] = cell_res[i].valid;
            if (cell_res[i].valid) begin
                sel = cell_res[i];
            end
        end
        emit_vec[SLOTS+1] = tail_probe.valid;
        if (tail_probe.valid) begin
            sel.valid = 1'b1;
            sel.last  = 1'b1;
            sel.slot  = '0;
            sel.mac   = '0;
            if (tail_probe.op == OP_INFO) begin
                sel.mac = tail_probe.mac;
                if (tail_probe.free_found) begin
                    sel.ev   = EV_ADDED;
                    sel.slot = tail_slot_ext[OUT_SLOT_W-1:0];
                end else begin
                    sel.ev = EV_FULL;
                end
            end else begin
                sel.ev = EV_DONE;
            end
        end
    end

    // output register parts the row from the result channel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= sel.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && sel.valid) begin
            ev_reg   <= sel.ev;
            slot_reg <= sel.slot;
            mac_reg  <= sel.mac;
            last_reg <= sel.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(56 - MAC_W - OUT_SLOT_W){1'b0}}, mac_reg, slot_reg};
    assign m_tuser  = ev_reg;
    assign m_tlast  = last_reg;

    // only one stage of the row ever holds the item
    `PTWA_ASSERT_ALWAYS(a_one_probe, aclk, aresetn, $onehot0(probe_vld))
    // never two result sources in the same cycle
    `PTWA_ASSERT_ALWAYS(a_one_emitter, aclk, aresetn, $onehot0(emit_vec))
    // an accepted beat closes the input until its work is through
    `PTWA_ASSERT_NEXT(a_accept_blocks, aclk, aresetn, accept, !s_tready && entry_reg.valid)

endmodule
